// File: rtl/xalu_pkg.sv
`timescale 1ns / 1ps

package xalu_pkg;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_ADC = 4'd1,
      OP_SUB = 4'd2,
      OP_SBB = 4'd3,
      OP_MUL = 4'd4,
      OP_AND = 4'd5,
      OP_XOR = 4'd6,
      OP_OR  = 4'd7,
      OP_SHL = 4'd8,
      OP_SHR = 4'd9,
      OP_SAR = 4'd10
   } op_type;

   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;

   localparam logic [31:0] MASK_8  = 32'h0000_00FF;
   localparam logic [31:0] MASK_16 = 32'h0000_FFFF;
   localparam logic [31:0] MASK_32 = 32'hFFFF_FFFF;

   localparam logic [63:0] MUL_HI_8  = 64'h0000_0000_0000_FF00;
   localparam logic [63:0] MUL_HI_16 = 64'h0000_0000_FFFF_0000;
   localparam logic [63:0] MUL_HI_32 = 64'hFFFF_FFFF_0000_0000;

   typedef struct packed {
      logic of;
      logic sf;
      logic zf;
      logic pf;
      logic cf;
   } flags_type;

   function automatic logic sized_msb(input logic [31:0] v, input logic [1:0] size);
      logic b;
      case (size)
         SIZE_8:  b = v[7];
         SIZE_16: b = v[15];
         default: b = v[31];
      endcase
      return b;
   endfunction

endpackage

// File: rtl/xalu_core.sv
`timescale 1ns / 1ps

module xalu_core
   import xalu_pkg::*;
(
   input  logic [3:0]  op,
   input  logic [1:0]  size,
   input  logic [31:0] src,
   input  logic [31:0] dst,
   input  flags_type   flags_cur,
   output logic [63:0] result,
   output flags_type   flags_nxt
);

   logic [31:0] mask;
   logic [5:0]  width;
   logic [31:0] d;
   logic [31:0] s;
   logic [31:0] dx;
   logic [63:0] mul_hi_mask;
   logic        cin_add;
   logic        cin_sub;
   logic [32:0] sum33;
   logic [32:0] diff33;
   logic [63:0] prod;
   logic        cnt_zero;
   logic        cnt_big;
   logic        cnt_over;
   logic [63:0] shl_wide;
   logic [32:0] shr_wide;
   logic [4:0]  sar_amt;
   logic [31:0] sar_val;
   logic        shift_cf;
   logic        valid_op;
   logic [31:0] low_res;
   logic        sd;
   logic        ss;
   logic        sr;

   always_comb begin
      case (size)
         SIZE_8: begin
            mask        = MASK_8;
            width       = 6'd8;
            mul_hi_mask = MUL_HI_8;
            dx          = {{24{dst[7]}}, dst[7:0]};
         end
         SIZE_16: begin
            mask        = MASK_16;
            width       = 6'd16;
            mul_hi_mask = MUL_HI_16;
            dx          = {{16{dst[15]}}, dst[15:0]};
         end
         default: begin
            mask        = MASK_32;
            width       = 6'd32;
            mul_hi_mask = MUL_HI_32;
            dx          = dst;
         end
      endcase
   end

   assign d = dst & mask;
   assign s = src & mask;

   assign cin_add = (op == OP_ADC) ? flags_cur.cf : 1'b0;
   assign cin_sub = (op == OP_SBB) ? flags_cur.cf : 1'b0;
   assign sum33   = {1'b0, d} + {1'b0, s} + {32'd0, cin_add};
   assign diff33  = {1'b0, d} - {1'b0, s} - {32'd0, cin_sub};
   assign prod    = d * s;

   // shift count is the full source word, not masked
   assign cnt_zero = (src == 32'd0);
   assign cnt_big  = (src >= {26'd0, width});
   assign cnt_over = (src > {26'd0, width});
   assign shl_wide = {32'd0, d} << src[5:0];
   assign shr_wide = {d, 1'b0} >> src[5:0];
   assign sar_amt  = (src > 32'd31) ? 5'd31 : src[4:0];
   assign sar_val  = 32'($signed(dx) >>> sar_amt) & mask;

   assign sd = sized_msb(d, size);
   assign ss = sized_msb(s, size);

   always_comb begin
      result    = 64'd0;
      flags_nxt = flags_cur;
      valid_op  = 1'b1;
      shift_cf  = 1'b0;
      sr        = 1'b0;
      case (op)
         OP_ADD, OP_ADC: begin
            result       = {32'd0, sum33[31:0] & mask};
            sr           = sized_msb(sum33[31:0], size);
            flags_nxt.cf = sum33[width];
            flags_nxt.of = (sd == ss) && (sr != sd);
         end
         OP_SUB, OP_SBB: begin
            result       = {32'd0, diff33[31:0] & mask};
            sr           = sized_msb(diff33[31:0], size);
            flags_nxt.cf = diff33[width];
            flags_nxt.of = (sd != ss) && (sr != sd);
         end
         OP_MUL: begin
            result       = prod;
            flags_nxt.cf = |(prod & mul_hi_mask);
            flags_nxt.of = |(prod & mul_hi_mask);
         end
         OP_AND, OP_XOR, OP_OR: begin
            if (op == OP_AND) begin
               result = {32'd0, d & s};
            end else if (op == OP_XOR) begin
               result = {32'd0, d ^ s};
            end else begin
               result = {32'd0, d | s};
            end
            flags_nxt.cf = 1'b0;
            flags_nxt.of = 1'b0;
         end
         OP_SHL: begin
            result   = cnt_big ? 64'd0 : {32'd0, shl_wide[31:0] & mask};
            shift_cf = cnt_over ? 1'b0 : shl_wide[width];
            if (!cnt_zero) begin
               flags_nxt.cf = shift_cf;
            end
         end
         OP_SHR, OP_SAR: begin
            if (op == OP_SAR) begin
               result = {32'd0, sar_val};
            end else begin
               result = cnt_big ? 64'd0 : {32'd0, shr_wide[32:1]};
            end
            shift_cf = cnt_over ? 1'b0 : shr_wide[0];
            if (!cnt_zero) begin
               flags_nxt.cf = shift_cf;
            end
         end
         default: begin
            valid_op = 1'b0;
         end
      endcase
      if (valid_op) begin
         flags_nxt.pf = ~^result[7:0];
         flags_nxt.zf = (low_res == 32'd0);
         flags_nxt.sf = sized_msb(low_res, size);
      end
   end

   assign low_res = result[31:0] & mask;

endmodule

// File: rtl/x86_integer_alu_with_flags.sv
`timescale 1ns / 1ps

// Integer ALU with x86 status flags (CF, PF, ZF, SF, OF) on 8, 16 and
// 32 bit operands. A word passes an input register, one stage of logic
// (adder, 32x32 multiplier or barrel shifter) and lands in the result
// register. A new word is taken every cycle unless the output stalls.
// The flags are held in one register that is updated as each word moves
// into the result register; adc and sbb of the next word read the carry
// left by the previous one, so back-to-back dependent words need no stall.
// The flag outputs always show the stored flags, which equal the flags of
// the word in the result register. Unknown operation codes give a zero
// result and leave the flags as they were.

module x86_integer_alu_with_flags
   import xalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_type,
   input  logic [1:0]  req_size_code,
   input  logic [31:0] req_source_operand,
   input  logic [31:0] req_dest_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_value,
   output logic        rsp_carry_out,
   output logic        rsp_parity_out,
   output logic        rsp_zero_out,
   output logic        rsp_sign_out,
   output logic        rsp_overflow_out
);

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [3:0]  s1_op_ff;
   logic [1:0]  s1_size_ff;
   logic [31:0] s1_src_ff;
   logic [31:0] s1_dst_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [63:0] out_result_ff;
   flags_type   flags_ff;
   flags_type   flags_in;
   logic [63:0] core_result;
   logic        advance;
   logic        req_take;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   xalu_core u_core (
      .op        (s1_op_ff),
      .size      (s1_size_ff),
      .src       (s1_src_ff),
      .dst       (s1_dst_ff),
      .flags_cur (flags_ff),
      .result    (core_result),
      .flags_nxt (flags_in)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_type;
         s1_size_ff <= req_size_code;
         s1_src_ff  <= req_source_operand;
         s1_dst_ff  <= req_dest_operand;
      end
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_result_ff;
   assign rsp_carry_out    = flags_ff.cf;
   assign rsp_parity_out   = flags_ff.pf;
   assign rsp_zero_out     = flags_ff.zf;
   assign rsp_sign_out     = flags_ff.sf;
   assign rsp_overflow_out = flags_ff.of;

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flags_ff))
      else $error("flags changed without a word moving to the result register");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result register not loaded after advance");

   a_logic_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_op_ff == OP_AND || s1_op_ff == OP_XOR || s1_op_ff == OP_OR)
      |=> !flags_ff.cf && !flags_ff.of)
      else $error("logic op left CF or OF set");

   a_mul_cf_of: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_op_ff == OP_MUL) |=> flags_ff.cf == flags_ff.of)
      else $error("mul CF and OF disagree");

endmodule
